### hdl/kda_pkg.sv
`default_nettype none

package kda_pkg;

    // Width of every configuration register.
    localparam int CFG_W = 10;

    // Default build parameters.
    localparam int KEY_BITS_DEF   = 8;
    localparam int TIMER_BITS_DEF = 10;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_DELAY    = 2'd1;
    localparam logic [1:0] REG_PERIOD   = 2'd2;

    // Timing constants in ticks.
    localparam logic [CFG_W-1:0] DEF_DEBOUNCE = 10'd5;
    localparam logic [CFG_W-1:0] DEF_DELAY    = 10'd150;
    localparam logic [CFG_W-1:0] DEF_PERIOD   = 10'd20;
    localparam logic [CFG_W-1:0] ARM_TICKS    = 10'd1;

    // Event codes carried in each result word.
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_PRESS  = 2'd1,
        EV_REPEAT = 2'd2
    } t_event;

    // Configuration register set.
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] repeat_delay;
        logic [CFG_W-1:0] repeat_period;
    } t_cfg;

endpackage

`default_nettype wire

### hdl/kda_if.sv
`default_nettype none

// Input channel: one pin sample per word.
interface kda_in_if #(
    parameter int KEY_BITS = kda_pkg::KEY_BITS_DEF
);
    logic                valid;
    logic                ready;
    logic                tick;
    logic [KEY_BITS-1:0] pin_levels;
    logic [KEY_BITS-1:0] key_sel;

    modport source (output valid, output tick, output pin_levels, output key_sel,
                    input ready);
    modport sink   (input valid, input tick, input pin_levels, input key_sel,
                    output ready);
endinterface

// Output channel: one result per input word.
interface kda_out_if;
    logic                 valid;
    logic                 ready;
    kda_pkg::t_event      event_res;
    logic                 locked_out;

    modport source (output valid, output event_res, output locked_out, input ready);
    modport sink   (input valid, input event_res, input locked_out, output ready);
endinterface

`default_nettype wire

### hdl/kda_engine.sv
`default_nettype none

// Debounce and auto-repeat state machine; state advances once per stepped word.
module kda_engine #(
    parameter int KEY_BITS   = kda_pkg::KEY_BITS_DEF,
    parameter int TIMER_BITS = kda_pkg::TIMER_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire logic                i_tick,
    input  wire logic [KEY_BITS-1:0] i_pin_levels,
    input  wire logic [KEY_BITS-1:0] i_key_sel,
    input  wire kda_pkg::t_cfg       i_cfg,
    output kda_pkg::t_event          o_event_res,
    output logic                     o_locked_out
);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_ARMED    = 3'd2,
        PH_WAIT     = 3'd3,
        PH_REPEAT   = 3'd4
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [KEY_BITS-1:0]   r_owner, n_owner;
    logic [TIMER_BITS-1:0] r_cd, n_cd;

    logic [TIMER_BITS-1:0] cd_ticked;
    logic [TIMER_BITS-1:0] eff_delay;
    logic [TIMER_BITS-1:0] eff_period;
    logic                  press;
    logic                  cd_zero;

    // Fit a register value into the countdown width.
    function automatic logic [TIMER_BITS-1:0] to_timer(input logic [kda_pkg::CFG_W-1:0] v);
        logic [kda_pkg::CFG_W+TIMER_BITS-1:0] ext;
        ext = {{TIMER_BITS{1'b0}}, v};
        return ext[TIMER_BITS-1:0];
    endfunction

    // A zero delay or period selects the built-in default.
    assign eff_delay  = to_timer((i_cfg.repeat_delay == '0) ? kda_pkg::DEF_DELAY
                                                            : i_cfg.repeat_delay);
    assign eff_period = to_timer((i_cfg.repeat_period == '0) ? kda_pkg::DEF_PERIOD
                                                             : i_cfg.repeat_period);

    // The tick decrements the countdown before the key is evaluated.
    assign cd_ticked = (i_tick && r_cd != '0) ? r_cd - TIMER_BITS'(1) : r_cd;
    assign cd_zero   = (cd_ticked == '0);

    assign o_locked_out = (r_owner != '0) && (r_owner != i_key_sel);
    assign press        = ((i_pin_levels & i_key_sel) == '0);

    // Phase transitions for the polled key.
    always_comb begin
        n_phase     = r_phase;
        n_owner     = r_owner;
        n_cd        = cd_ticked;
        o_event_res = kda_pkg::EV_NONE;
        if (!o_locked_out) begin
            priority if (press && r_phase == PH_IDLE) begin
                n_phase = PH_DEBOUNCE;
                n_cd    = to_timer(i_cfg.debounce_ticks);
            end else if (r_phase == PH_IDLE) begin
                n_phase = PH_IDLE;
            end else if (press && r_phase == PH_DEBOUNCE && cd_zero) begin
                n_phase = PH_ARMED;
                n_cd    = to_timer(kda_pkg::ARM_TICKS);
                n_owner = i_key_sel;
            end else if (!press && (r_phase == PH_ARMED || r_phase == PH_WAIT)) begin
                o_event_res = kda_pkg::EV_PRESS;
                n_phase     = PH_IDLE;
                n_owner     = '0;
            end else if (press && r_phase == PH_ARMED && cd_zero) begin
                n_phase = PH_WAIT;
                n_cd    = eff_delay;
            end else if (press && r_phase == PH_WAIT && cd_zero) begin
                n_phase = PH_REPEAT;
            end else if (press && r_phase == PH_REPEAT && cd_zero) begin
                n_cd        = eff_period;
                o_event_res = kda_pkg::EV_REPEAT;
            end else if (!press && r_phase == PH_REPEAT) begin
                // Release while repeating ends silently.
                n_phase = PH_IDLE;
                n_owner = '0;
            end else begin
                n_phase = r_phase;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_owner <= '0;
            r_cd    <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_owner <= n_owner;
            r_cd    <= n_cd;
        end
    end

endmodule

`default_nettype wire

### hdl/key_debounce_autorepeat_core.sv
// Key debouncer with auto-repeat.
// Input channel i_in carries one word per poll: a tick flag, the raw pin byte
// (a key is pressed when its bit is low) and a one-hot mask naming the key.
// Output channel o_out returns exactly one word per input word: an event code
// (none, short press, auto-repeat) and a flag that another key owns the block.
// The APB port holds three 10-bit registers at byte addresses 0, 4 and 8:
// debounce ticks, repeat delay and repeat period. Writes land in the access
// cycle; pready is always high. The user must change registers only while the
// block is idle; the block itself does not enforce this. A word accepted into
// the input register is stepped once the result slot frees, and its result is
// then held in the result register and valid on o_out. Throughput: one word
// per cycle while the receiver does not stall; the state update is combinational.
// When the receiver stalls, the result holds and the input register keeps
// one more word; i_in.ready drops only when both are full.
// Synchronous reset returns the registers to their defaults (5, 0, 0), the
// key state to idle with no owner and a zero countdown, and empties both stages.
`default_nettype none

module key_debounce_autorepeat_core #(
    parameter int KEY_BITS   = kda_pkg::KEY_BITS_DEF,
    parameter int TIMER_BITS = kda_pkg::TIMER_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    kda_in_if.sink                               i_in,
    kda_out_if.source                            o_out,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [kda_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [kda_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [kda_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    kda_pkg::t_cfg       r_cfg;
    logic [1:0]          reg_idx;
    logic                cfg_wr;

    logic                r_s1_valid;
    logic                r_s1_tick;
    logic [KEY_BITS-1:0] r_s1_pins;
    logic [KEY_BITS-1:0] r_s1_mask;

    logic                r_out_valid;
    kda_pkg::t_event     r_out_event;
    logic                r_out_locked;

    logic                advance;
    logic                fire;
    logic                in_take;
    kda_pkg::t_event     step_event;
    logic                step_locked;

    // Configuration registers.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= kda_pkg::DEF_DEBOUNCE;
            r_cfg.repeat_delay   <= '0;
            r_cfg.repeat_period  <= '0;
        end else if (cfg_wr) begin
            if (reg_idx == kda_pkg::REG_DEBOUNCE) begin
                r_cfg.debounce_ticks <= pwdata[kda_pkg::CFG_W-1:0];
            end
            if (reg_idx == kda_pkg::REG_DELAY) begin
                r_cfg.repeat_delay <= pwdata[kda_pkg::CFG_W-1:0];
            end
            if (reg_idx == kda_pkg::REG_PERIOD) begin
                r_cfg.repeat_period <= pwdata[kda_pkg::CFG_W-1:0];
            end
        end
    end

    // Register read-back.
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            kda_pkg::REG_DEBOUNCE: prdata[kda_pkg::CFG_W-1:0] = r_cfg.debounce_ticks;
            kda_pkg::REG_DELAY:    prdata[kda_pkg::CFG_W-1:0] = r_cfg.repeat_delay;
            kda_pkg::REG_PERIOD:   prdata[kda_pkg::CFG_W-1:0] = r_cfg.repeat_period;
            default:               prdata = '0;
        endcase
    end

    // Pipeline handshake: the input stage moves whenever the result slot frees.
    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_s1_valid && advance;
    assign i_in.ready = !r_s1_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_tick <= i_in.tick;
            r_s1_pins <= i_in.pin_levels;
            r_s1_mask <= i_in.key_sel;
        end
    end

    kda_engine #(
        .KEY_BITS   (KEY_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (fire),
        .i_tick       (r_s1_tick),
        .i_pin_levels (r_s1_pins),
        .i_key_sel    (r_s1_mask),
        .i_cfg        (r_cfg),
        .o_event_res  (step_event),
        .o_locked_out (step_locked)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_event  <= step_event;
            r_out_locked <= step_locked;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_res  = r_out_event;
    assign o_out.locked_out = r_out_locked;

endmodule

`default_nettype wire

### hdl/kda_checker.sv
`default_nettype none

// Port-level checks on the debouncer's result channel.
module kda_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire kda_pkg::t_event i_event_res,
    input wire logic            i_locked_out
);

    // A reset leaves the result channel empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A locked-out poll never reports an event.
    a_locked_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_locked_out) |-> (i_event_res == kda_pkg::EV_NONE))
        else $error("event reported on a locked-out poll");

    // Only the three defined event codes appear.
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_event_res == kda_pkg::EV_NONE ||
                         i_event_res == kda_pkg::EV_PRESS ||
                         i_event_res == kda_pkg::EV_REPEAT))
        else $error("undefined event code");

    // A stalled result holds its word.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_event_res) && $stable(i_locked_out)))
        else $error("stalled result changed");

endmodule

bind key_debounce_autorepeat_core kda_checker u_kda_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_event_res  (o_out.event_res),
    .i_locked_out (o_out.locked_out)
);

`default_nettype wire
